FILE: hw/rtl/bsht_pkg.sv
// ============================================================================
// bsht_pkg - shared types and constants for the score hash table
// Slot layout, operation and bound codes, table geometry.
// ============================================================================
package bsht_pkg;

  // table geometry
  localparam int ENTRIES    = 1024;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam bit ENTRY_POW2 = ((ENTRIES & (ENTRIES - 1)) == 0);

  localparam int KEY_W   = 64;
  localparam int MOVE_W  = 16;
  localparam int SCORE_W = 16;
  localparam int DEPTH_W = 8;
  localparam int BOUND_W = 2;
  localparam int GEN_W   = 8;

  // operation codes
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_REFINE = 2'd1;
  localparam logic [1:0] OP_INSERT = 2'd2;

  // bound codes
  localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
  localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd1;
  localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd2;

  localparam logic signed [SCORE_W-1:0] SCORE_LOWEST = 16'sh8000;

  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic [MOVE_W-1:0]         mv;
    logic signed [SCORE_W-1:0] score;
    logic [DEPTH_W-1:0]        depth;
    logic [BOUND_W-1:0]        bound;
    logic [GEN_W-1:0]          gen;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  localparam slot_t SLOT_RESET = '{
    key:   '0,
    mv:    '0,
    score: SCORE_LOWEST,
    depth: '0,
    bound: BOUND_EXACT,
    gen:   '0
  };

  // one accepted request, held while it executes
  typedef struct packed {
    logic [1:0]                op;
    logic [KEY_W-1:0]          key;
    logic [DEPTH_W-1:0]        depth;
    logic signed [SCORE_W-1:0] alpha;
    logic signed [SCORE_W-1:0] beta;
    logic [MOVE_W-1:0]         mv;
    logic signed [SCORE_W-1:0] score;
  } req_t;

  // slot index unit status
  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] idx;
  } idx_res_t;

endpackage

FILE: hw/rtl/bsht_if.sv
// ============================================================================
// bsht_if - request and result channels of the score hash table
// Valid/ready channels; an item moves when valid and ready are both high.
// ============================================================================
interface bsht_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [63:0] key;
  logic [7:0]  depth_left;
  logic signed [15:0] alpha;
  logic signed [15:0] beta;
  logic [15:0] move_in;
  logic signed [15:0] score_in;

  modport source (
    output valid, operation, key, depth_left, alpha, beta, move_in, score_in,
    input  ready
  );
  modport sink (
    input  valid, operation, key, depth_left, alpha, beta, move_in, score_in,
    output ready
  );
endinterface

interface bsht_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [15:0] move_out;
  logic signed [15:0] score_out;
  logic signed [15:0] alpha_out;
  logic signed [15:0] beta_out;
  logic        stored;

  modport source (
    output valid, hit, move_out, score_out, alpha_out, beta_out, stored,
    input  ready
  );
  modport sink (
    input  valid, hit, move_out, score_out, alpha_out, beta_out, stored,
    output ready
  );
endinterface

FILE: hw/rtl/bsht_ram.sv
// ============================================================================
// bsht_ram - simple dual-port synchronous RAM
// One write port, one read port, registered read data.
// ============================================================================
module bsht_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/bsht_slot_idx.sv
// ============================================================================
// bsht_slot_idx - slot number from key (key modulo table size)
// Power-of-two tables: a mask, ready at once. Otherwise: key bytes folded
// against the constants 2^(8i) mod N, then a shifted compare-and-subtract
// on the registered sum, pass by pass.
// ============================================================================
module bsht_slot_idx (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [bsht_pkg::KEY_W-1:0] key,
  output bsht_pkg::idx_res_t       res
);

  localparam int IDX_W = bsht_pkg::IDX_W;

  if (bsht_pkg::ENTRY_POW2) begin : g_mask
    localparam logic [IDX_W-1:0] MASK = IDX_W'(bsht_pkg::ENTRIES - 1);

    always_comb begin
      res.done = 1'b1;
      res.idx  = key[IDX_W-1:0] & MASK;
    end
  end else begin : g_fold
    localparam int BYTES  = bsht_pkg::KEY_W / 8;
    localparam int QB     = 11;                  // folded sum < 2^11 * N
    localparam int S_W    = IDX_W + QB;
    localparam int STEPS  = 4;                   // subtract steps per cycle
    localparam int PASSES = (QB + STEPS - 1) / STEPS;
    localparam logic [S_W-1:0] ENT_S = S_W'(bsht_pkg::ENTRIES);

    // 2^(8i) mod N for each key byte
    function automatic logic [BYTES*IDX_W-1:0] byte_mods();
      logic [BYTES*IDX_W-1:0] v;
      longint unsigned        r;
      v = '0;
      r = 64'd1;
      for (int i = 0; i < BYTES; i++) begin
        v[IDX_W*i +: IDX_W] = IDX_W'(r);
        r = (r << 8) % 64'(bsht_pkg::ENTRIES);
      end
      return v;
    endfunction

    localparam logic [BYTES*IDX_W-1:0] BYTE_MOD = byte_mods();

    logic             busy_r;
    logic [1:0]       pass_r;
    logic [S_W-1:0]   sum_r;
    logic [S_W-1:0]   sum_c;
    logic [S_W-1:0]   red_c;

    // sum of byte * (2^(8i) mod N), congruent to key mod N
    always_comb begin
      sum_c = '0;
      for (int i = 0; i < BYTES; i++) begin
        sum_c = sum_c + S_W'(key[8*i +: 8]) * S_W'(BYTE_MOD[IDX_W*i +: IDX_W]);
      end
    end

    // take off N << k for the k values of this pass, highest first
    always_comb begin
      int k;
      red_c = sum_r;
      for (int j = 0; j < STEPS; j++) begin
        k = QB - 1 - STEPS * int'(pass_r) - j;
        if (k >= 0) begin
          if (red_c >= (ENT_S << k)) begin
            red_c = red_c - (ENT_S << k);
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        busy_r <= 1'b0;
        pass_r <= '0;
      end else if (start) begin
        busy_r <= 1'b1;
        pass_r <= '0;
      end else if (busy_r) begin
        pass_r <= pass_r + 1'b1;
        if (pass_r == 2'(PASSES - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        sum_r <= sum_c;
      end else if (busy_r) begin
        sum_r <= red_c;
      end
    end

    always_comb begin
      res.done = busy_r && (pass_r == 2'(PASSES - 1));
      res.idx  = red_c[IDX_W-1:0];
    end
  end

endmodule

FILE: hw/rtl/bounded_score_hash_table.sv
// ============================================================================
// bounded_score_hash_table - direct-mapped transposition table
// Lookup, bound refine and insert against one slot per key, slot state in
// a single synchronous RAM, read-modify-write per item.
// ============================================================================
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------
//  in_ch   | in  | valid/ready        | operation, key, depth_left, alpha,
//          |     |                    | beta, move_in, score_in
//  out_ch  | out | valid/ready        | hit, move_out, score_out, alpha_out,
//          |     |                    | beta_out, stored
//  cfg_    | in  | cfg_we, no stall   | cfg_wdata = generation
//
// Sequence: with a power-of-two table, accept + slot read, then
// modify/write-back + result. Other table sizes wait in ST_WAIT for the
// folded slot remainder between the two. The RAM port pair sets this.
// Reset: a clearing pass writes the reset entry to every slot, with
// in_ch.ready low; generation writes are taken meanwhile.
// Stalls: the result register frees as it is taken, so a new item is taken
// in the same cycle that out_ch drains. One item in flight, so no same-slot
// hazard: the write-back always lands before the next read.
// ============================================================================
module bounded_score_hash_table (
  input  logic                 clk,
  input  logic                 rst_n,
  bsht_in_if.sink              in_ch,
  bsht_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata
);

  localparam int IDX_W = bsht_pkg::IDX_W;

  // sequencer states
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;  // slot number still being worked out
  localparam logic [1:0] ST_EXEC  = 2'd3;  // slot data present, modify + write

  logic [1:0]              state_r, state_nxt;
  logic [IDX_W-1:0]        clr_cnt_r;
  logic [7:0]              gen_r;
  bsht_pkg::req_t          req_r;
  logic [IDX_W-1:0]        slot_r;

  logic                    accept;
  bsht_pkg::idx_res_t      idx_res;

  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  bsht_pkg::slot_t         ram_wdata;
  bsht_pkg::slot_t         ram_rdata;

  // result register
  logic                    out_valid_r;
  logic                    hit_r, stored_r;
  logic [15:0]             move_r;
  logic signed [15:0]      score_r, alpha_r, beta_r;

  // execute-stage results
  logic                    match;
  logic                    hit_c, stored_c, wr_ok;
  logic [15:0]             move_c;
  logic signed [15:0]      score_c, alpha_c, beta_c;
  logic [1:0]              kind;
  logic                    keep;

  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  // slot number from key; mask case answers in the accept cycle
  bsht_slot_idx u_idx (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .key   (in_ch.key),
    .res   (idx_res)
  );

  bsht_ram #(
    .WIDTH (bsht_pkg::SLOT_W),
    .DEPTH (bsht_pkg::ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_res.idx),
    .rdata (ram_rdata)
  );

  // ---- sequencer --------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == IDX_W'(bsht_pkg::ENTRIES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = idx_res.done ? ST_EXEC : ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (idx_res.done) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      gen_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cfg_we) begin
        gen_r <= cfg_wdata;
      end
    end
  end

  // hold the request and its slot number until write-back
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.op    <= in_ch.operation;
      req_r.key   <= in_ch.key;
      req_r.depth <= in_ch.depth_left;
      req_r.alpha <= in_ch.alpha;
      req_r.beta  <= in_ch.beta;
      req_r.mv    <= in_ch.move_in;
      req_r.score <= in_ch.score_in;
    end
    if (idx_res.done) begin
      slot_r <= idx_res.idx;
    end
  end

  // ---- execute: compare, refine, insert decision ------------------------
  always_comb begin
    match    = (ram_rdata.key == req_r.key);
    hit_c    = 1'b0;
    stored_c = 1'b0;
    move_c   = '0;
    score_c  = bsht_pkg::SCORE_LOWEST;
    alpha_c  = req_r.alpha;
    beta_c   = req_r.beta;

    // insert classification against the window
    if (req_r.score > req_r.alpha && req_r.score < req_r.beta) begin
      kind = bsht_pkg::BOUND_EXACT;
    end else if (req_r.score <= req_r.alpha) begin
      kind = bsht_pkg::BOUND_UPPER;
    end else begin
      kind = bsht_pkg::BOUND_LOWER;
    end

    // deeper exact entry of this generation survives unless beaten
    keep = (ram_rdata.bound == bsht_pkg::BOUND_EXACT) &&
           (req_r.depth < ram_rdata.depth) &&
           (ram_rdata.mv != '0) &&
           ((kind != bsht_pkg::BOUND_EXACT) || (req_r.score <= ram_rdata.score)) &&
           (ram_rdata.gen == gen_r);

    wr_ok = (req_r.mv != '0) && (req_r.depth != '0) && !keep;

    case (req_r.op)
      bsht_pkg::OP_LOOKUP: begin
        if (match) begin
          hit_c   = 1'b1;
          move_c  = ram_rdata.mv;
          score_c = ram_rdata.score;
        end
      end
      bsht_pkg::OP_REFINE: begin
        if (match && (ram_rdata.depth >= req_r.depth) && (ram_rdata.gen == gen_r)) begin
          hit_c = 1'b1;
          case (ram_rdata.bound)
            bsht_pkg::BOUND_EXACT: begin
              alpha_c = ram_rdata.score;
              beta_c  = ram_rdata.score;
            end
            bsht_pkg::BOUND_LOWER: begin
              if (ram_rdata.score > req_r.alpha) begin
                alpha_c = ram_rdata.score;
              end
            end
            bsht_pkg::BOUND_UPPER: begin
              if (ram_rdata.score < req_r.beta) begin
                beta_c = ram_rdata.score;
              end
            end
            default: begin
              // unused bound code: bounds untouched
            end
          endcase
        end
      end
      bsht_pkg::OP_INSERT: begin
        stored_c = wr_ok;
      end
      default: begin
        // unused op code: answers as a lookup miss
      end
    endcase
  end

  // ---- slot write port: clearing pass or insert write-back --------------
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_r;
    ram_wdata = bsht_pkg::SLOT_RESET;
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
    end else if (state_r == ST_EXEC && stored_c) begin
      ram_we          = 1'b1;
      ram_wdata.key   = req_r.key;
      ram_wdata.mv    = req_r.mv;
      ram_wdata.score = req_r.score;
      ram_wdata.depth = req_r.depth;
      ram_wdata.bound = kind;
      ram_wdata.gen   = gen_r;
    end
  end

  // ---- result register --------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_EXEC) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EXEC) begin
      hit_r    <= hit_c;
      move_r   <= move_c;
      score_r  <= score_c;
      alpha_r  <= alpha_c;
      beta_r   <= beta_c;
      stored_r <= stored_c;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.hit       = hit_r;
  assign out_ch.move_out  = move_r;
  assign out_ch.score_out = score_r;
  assign out_ch.alpha_out = alpha_r;
  assign out_ch.beta_out  = beta_r;
  assign out_ch.stored    = stored_r;

`ifndef SYNTHESIS
  // slot RAM is only written by the clearing pass or an insert write-back
  a_we_src: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CLEAR) ||
               (state_r == ST_EXEC && req_r.op == bsht_pkg::OP_INSERT))
    else $error("slot write outside clear or insert");

  // an accepted item goes on to the slot read
  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_EXEC) || (state_r == ST_WAIT))
    else $error("accepted item not taken into execution");

  // result register is free whenever a result is produced
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |-> !out_valid_r)
    else $error("result overwrites an untaken item");

  // every execution leaves a result behind
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |=> out_valid_r)
    else $error("execution without result");
`endif

endmodule

FILE: verif/bounded_score_hash_table_test.sv
// ============================================================================
// bounded_score_hash_table_test - self-checking bench for the score hash table
// Drives lookup, refine and insert items through the valid/ready request
// channel, predicts every answer from a shadow copy of the slot store and
// the search generation, and checks each answer field by field.
// ============================================================================
module bounded_score_hash_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  // operation code 3 is unused by the block: it answers like a lookup miss
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // keys in play for the random part; pairs (2i, 2i+1) share a slot
  localparam int POOL_SIZE = 48;

  // one answer as it leaves out_ch
  typedef struct packed {
    logic                                hit;
    logic [bsht_pkg::MOVE_W-1:0]         mv;
    logic signed [bsht_pkg::SCORE_W-1:0] score;
    logic signed [bsht_pkg::SCORE_W-1:0] alpha;
    logic signed [bsht_pkg::SCORE_W-1:0] beta;
    logic                                stored;
  } answer_t;

  // --------------------------------------------------------------------------
  // Shadow of the slot store: predicts the answer of every accepted item and
  // holds the answers still owed by the block, oldest first.
  // --------------------------------------------------------------------------
  class table_shadow;
    bsht_pkg::slot_t             slots[bsht_pkg::ENTRIES];
    logic [bsht_pkg::GEN_W-1:0]  generation;
    answer_t                     pending[$];
    int unsigned                 mismatches;

    function new();
      foreach (slots[i]) slots[i] = bsht_pkg::SLOT_RESET;
      generation = '0;
      mismatches = 0;
    endfunction

    // applies one item to the shadow store and returns the answer it gives
    function answer_t predict_answer(bsht_pkg::req_t r);
      int unsigned                  idx;
      bsht_pkg::slot_t              s;
      logic                         match;
      logic                         keep;
      logic [bsht_pkg::BOUND_W-1:0] kind;
      answer_t                      a;
      idx = int'(r.key % 64'(bsht_pkg::ENTRIES));
      s = slots[idx];
      match = (s.key == r.key);
      a.hit = 1'b0;
      a.mv = '0;
      a.score = bsht_pkg::SCORE_LOWEST;
      a.alpha = r.alpha;
      a.beta = r.beta;
      a.stored = 1'b0;
      case (r.op)
        bsht_pkg::OP_LOOKUP: begin
          if (match) begin
            a.hit = 1'b1;
            a.mv = s.mv;
            a.score = s.score;
          end
        end
        bsht_pkg::OP_REFINE: begin
          if (match && s.depth >= r.depth && s.gen == generation) begin
            a.hit = 1'b1;
            case (s.bound)
              bsht_pkg::BOUND_EXACT: begin
                a.alpha = s.score;
                a.beta = s.score;
              end
              bsht_pkg::BOUND_LOWER: if (s.score > r.alpha) a.alpha = s.score;
              bsht_pkg::BOUND_UPPER: if (s.score < r.beta) a.beta = s.score;
              default: ;
            endcase
          end
        end
        bsht_pkg::OP_INSERT: begin
          if (r.score > r.alpha && r.score < r.beta) kind = bsht_pkg::BOUND_EXACT;
          else if (r.score <= r.alpha) kind = bsht_pkg::BOUND_UPPER;
          else kind = bsht_pkg::BOUND_LOWER;
          if (r.mv != '0 && r.depth >= 1) begin
            // a deeper exact entry of this generation survives unless the
            // new result is exact and scores higher
            keep = s.bound == bsht_pkg::BOUND_EXACT && r.depth < s.depth &&
                   s.mv != '0 &&
                   (kind != bsht_pkg::BOUND_EXACT || r.score <= s.score) &&
                   s.gen == generation;
            if (!keep) begin
              slots[idx] = '{key: r.key, mv: r.mv, score: r.score, depth: r.depth,
                             bound: kind, gen: generation};
              a.stored = 1'b1;
            end
          end
        end
        default: ;
      endcase
      return a;
    endfunction

    function void note_request(bsht_pkg::req_t r);
      answer_t a;
      a = predict_answer(r);
      pending = {pending, a};
    endfunction

    function void compare_field(string name, int expd, int got);
      if (expd != got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, expd, got);
        mismatches++;
      end
    endfunction

    function void check_answer(answer_t got);
      answer_t expd;
      if (pending.size() == 0) begin
        $error("answer with none outstanding: hit %0d move %0d score %0d",
               got.hit, got.mv, got.score);
        mismatches++;
        return;
      end
      expd = pending.pop_front();
      compare_field("hit", expd.hit, got.hit);
      compare_field("move_out", expd.mv, got.mv);
      compare_field("score_out", expd.score, got.score);
      compare_field("alpha_out", expd.alpha, got.alpha);
      compare_field("beta_out", expd.beta, got.beta);
      compare_field("stored", expd.stored, got.stored);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [bsht_pkg::GEN_W-1:0] cfg_wdata;

  bsht_in_if  in_ch();
  bsht_out_if out_ch();

  bounded_score_hash_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  table_shadow shadow = new();

  logic [bsht_pkg::KEY_W-1:0] key_pool[POOL_SIZE];

  // set by the sequence: both sides run without gaps
  bit no_idle;
  // set by the sequence: receiver holds ready low for this many cycles
  int hold_req;

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop well beyond the slowest legitimate run
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: checks every answer taken and idles at random. A hold request
  // from the sequence is counted down here, one cycle at a time.
  // --------------------------------------------------------------------------
  initial begin
    int stall_left;
    int r;
    answer_t got;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.hit = out_ch.hit;
        got.mv = out_ch.move_out;
        got.score = out_ch.score_out;
        got.alpha = out_ch.alpha_out;
        got.beta = out_ch.beta_out;
        got.stored = out_ch.stored;
        shadow.check_answer(got);
      end
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (no_idle) begin
        out_ch.ready <= 1'b1;
      end else begin
        // mostly ready, short stalls often, long ones now and then
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_ch.ready <= 1'b1;
        end else if (r < 96) begin
          out_ch.ready <= 1'b0;
          stall_left = $urandom_range(0, 2);
        end else begin
          out_ch.ready <= 1'b0;
          stall_left = $urandom_range(9, 29);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  function automatic bsht_pkg::req_t make_req(logic [1:0] op,
                                              logic [bsht_pkg::KEY_W-1:0] key,
                                              int depth, int alpha, int beta,
                                              int mv, int score);
    bsht_pkg::req_t r;
    r.op = op;
    r.key = key;
    r.depth = bsht_pkg::DEPTH_W'(depth);
    r.alpha = bsht_pkg::SCORE_W'(alpha);
    r.beta = bsht_pkg::SCORE_W'(beta);
    r.mv = bsht_pkg::MOVE_W'(mv);
    r.score = bsht_pkg::SCORE_W'(score);
    return r;
  endfunction

  // offers one item and returns at the edge where it is taken
  task automatic send_request(bsht_pkg::req_t r);
    in_ch.valid <= 1'b1;
    in_ch.operation <= r.op;
    in_ch.key <= r.key;
    in_ch.depth_left <= r.depth;
    in_ch.alpha <= r.alpha;
    in_ch.beta <= r.beta;
    in_ch.move_in <= r.mv;
    in_ch.score_in <= r.score;
    do @(posedge clk); while (!in_ch.ready);
    shadow.note_request(r);
  endtask

  // gap after an item: usually none, often short, a few long
  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) n = 0;
    else if (r < 93) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 30);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // holds the sender until every answer owed has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (shadow.pending.size() != 0) @(posedge clk);
  endtask

  // only called with nothing in flight
  task automatic write_generation(logic [bsht_pkg::GEN_W-1:0] g);
    cfg_we <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow.generation = g;
  endtask

  // fresh keys from pair 'from' upwards; odd entries alias their even partner
  function automatic void refill_pool(int from);
    for (int i = from; i < POOL_SIZE; i += 2) begin
      key_pool[i] = {$urandom, $urandom};
      key_pool[i+1] = {$urandom, $urandom};
      key_pool[i+1][bsht_pkg::IDX_W-1:0] = key_pool[i][bsht_pkg::IDX_W-1:0];
    end
  endfunction

  // Mostly well-formed traffic on pooled keys, so inserts are followed by
  // hitting lookups and refines; the rest is unconstrained noise.
  function automatic bsht_pkg::req_t random_request();
    bsht_pkg::req_t r;
    int sel;
    int centre;
    int alpha;
    int beta;
    int tmp;
    int score;
    sel = $urandom_range(0, 99);
    if (sel < 12) begin
      r.op = 2'($urandom_range(0, 3));
      r.key = {$urandom, $urandom};
      r.depth = bsht_pkg::DEPTH_W'($urandom);
      r.alpha = bsht_pkg::SCORE_W'($urandom);
      r.beta = bsht_pkg::SCORE_W'($urandom);
      r.mv = bsht_pkg::MOVE_W'($urandom);
      r.score = bsht_pkg::SCORE_W'($urandom);
      return r;
    end
    sel = $urandom_range(0, 99);
    if (sel < 42) r.op = bsht_pkg::OP_INSERT;
    else if (sel < 72) r.op = bsht_pkg::OP_REFINE;
    else if (sel < 97) r.op = bsht_pkg::OP_LOOKUP;
    else r.op = OP_UNUSED;
    r.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    if ($urandom_range(0, 9) == 0) r.depth = bsht_pkg::DEPTH_W'($urandom_range(0, 255));
    else r.depth = bsht_pkg::DEPTH_W'($urandom_range(0, 10));
    centre = int'($urandom_range(0, 400)) - 200;
    alpha = centre - int'($urandom_range(0, 60));
    beta = centre + int'($urandom_range(0, 60));
    // crossed window now and then
    if ($urandom_range(0, 19) == 0) begin
      tmp = alpha;
      alpha = beta;
      beta = tmp;
    end
    score = centre + int'($urandom_range(0, 160)) - 80;
    sel = $urandom_range(0, 39);
    if (sel == 0) score = -32768;
    else if (sel == 1) score = 32767;
    r.alpha = bsht_pkg::SCORE_W'(alpha);
    r.beta = bsht_pkg::SCORE_W'(beta);
    r.score = bsht_pkg::SCORE_W'(score);
    if ($urandom_range(0, 9) == 0) r.mv = '0;
    else r.mv = bsht_pkg::MOVE_W'($urandom_range(1, 65535));
    return r;
  endfunction

  task automatic run_random(int count);
    repeat (count) begin
      send_request(random_request());
      idle_gap();
    end
  endtask

  task automatic run_phase(logic [bsht_pkg::GEN_W-1:0] g, int count);
    wait_drained();
    write_generation(g);
    refill_pool(POOL_SIZE / 2);
    run_random(count);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  localparam logic [bsht_pkg::KEY_W-1:0] KEY_A    = 64'h0123_4567_89AB_C155;
  localparam logic [bsht_pkg::KEY_W-1:0] KEY_B    = 64'hFEDC_BA98_7654_3155; // slot of KEY_A
  localparam logic [bsht_pkg::KEY_W-1:0] KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [bsht_pkg::KEY_W-1:0] KEY_C    = 64'h8000_0000_0000_0200;

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    no_idle = 1'b0;
    hold_req = 0;
    in_ch.valid = 1'b0;
    in_ch.operation = bsht_pkg::OP_LOOKUP;
    in_ch.key = '0;
    in_ch.depth_left = '0;
    in_ch.alpha = '0;
    in_ch.beta = '0;
    in_ch.move_in = '0;
    in_ch.score_in = '0;
    refill_pool(0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    // the clearing pass keeps ready low; the write is taken meanwhile
    write_generation(8'd0);

    // ---- directed part, generation 0 ----
    // never-written slot 0 matches key zero
    send_request(make_req(bsht_pkg::OP_LOOKUP, '0, 0, 0, 0, 0, 0));
    // refine of that empty slot at depth 0 pins both bounds to the lowest
    send_request(make_req(bsht_pkg::OP_REFINE, '0, 0, -100, 100, 0, 0));
    // one ply more than the slot holds: no refine
    send_request(make_req(bsht_pkg::OP_REFINE, '0, 1, -100, 100, 0, 0));
    // all-ones key against an empty slot: miss
    send_request(make_req(bsht_pkg::OP_LOOKUP, KEY_ONES, 0, 32767, -32768, 0, 0));
    // unused operation answers like a miss
    send_request(make_req(OP_UNUSED, '0, 3, 7, 9, 11, 13));
    // empty move and zero depth are never written
    send_request(make_req(bsht_pkg::OP_INSERT, KEY_A, 5, -50, 50, 0, 10));
    send_request(make_req(bsht_pkg::OP_INSERT, KEY_A, 0, -50, 50, 5, 10));
    // exact entry, then refine at and beyond its depth
    send_request(make_req(bsht_pkg::OP_INSERT, KEY_A, 5, -50, 50, 16'h1234, 10));
    send_request(make_req(bsht_pkg::OP_REFINE, KEY_A, 5, -50, 50, 0, 0));
    send_request(make_req(bsht_pkg::OP_REFINE, KEY_A, 6, -50, 50, 0, 0));
    // shallower exact, not better: deeper entry kept
    send_request(make_req(bsht_pkg::OP_INSERT, KEY_A, 3, -50, 50, 16'h0001, 5));
    // shallower exact, better: replaces
    send_request(make_req(bsht_pkg::OP_INSERT, KEY_A, 3, -50, 50, 16'h0002, 20));
    send_request(make_req(bsht_pkg::OP_LOOKUP, KEY_A, 0, 0, 0, 0, 0));
    // colliding key, score at beta: lower bound, full-width fields
    send_request(make_req(bsht_pkg::OP_INSERT, KEY_B, 255, -32768, 32767, 16'hFFFF,
                          32767));
    send_request(make_req(bsht_pkg::OP_REFINE, KEY_B, 255, -32768, 0, 0, 0));
    // KEY_A was evicted
    send_request(make_req(bsht_pkg::OP_LOOKUP, KEY_A, 0, 1, 2, 0, 0));
    // score at alpha: upper bound
    send_request(make_req(bsht_pkg::OP_INSERT, KEY_ONES, 4, -32768, 100, 16'h8000,
                          -32768));
    send_request(make_req(bsht_pkg::OP_REFINE, KEY_ONES, 1, -10, 50, 0, 0));
    send_request(make_req(bsht_pkg::OP_LOOKUP, KEY_ONES, 0, 0, 0, 0, 0));
    // crossed bounds are taken as given
    send_request(make_req(bsht_pkg::OP_INSERT, KEY_C, 2, 100, -100, 16'h00AA, 0));
    send_request(make_req(bsht_pkg::OP_REFINE, KEY_C, 2, 100, -100, 0, 0));

    // ---- generation moves on: refine misses, lookup still hits ----
    wait_drained();
    write_generation(8'd255);
    send_request(make_req(bsht_pkg::OP_REFINE, KEY_ONES, 1, -10, 50, 0, 0));
    send_request(make_req(bsht_pkg::OP_LOOKUP, KEY_ONES, 0, 0, 0, 0, 0));
    // older lower-bound entry of KEY_B's slot is overwritten from a new generation
    send_request(make_req(bsht_pkg::OP_INSERT, KEY_A, 1, -50, 50, 16'h0003, 0));
    send_request(make_req(bsht_pkg::OP_REFINE, KEY_A, 1, -50, 50, 0, 0));

    // ---- random part ----
    run_phase(8'd255, 300);
    // wraps back to zero
    run_phase(8'd0, 300);

    // a stretch with no idling on either side
    wait_drained();
    write_generation(8'd1);
    refill_pool(POOL_SIZE / 2);
    no_idle = 1'b1;
    run_random(100);
    no_idle = 1'b0;
    run_random(150);

    // back-pressure: receiver holds off for a long stretch while the sender
    // keeps offering, so the block fills and stalls its input; then the
    // sender pauses until everything has drained
    wait_drained();
    write_generation(8'($urandom_range(2, 254)));
    refill_pool(POOL_SIZE / 2);
    hold_req = 300;
    repeat (40) send_request(random_request());
    wait_drained();
    run_random(260);

    run_phase(8'd128, 300);
    run_phase(8'($urandom), 400);

    // drain, then a few cycles for anything stray
    wait_drained();
    repeat (10) @(posedge clk);

    if (shadow.mismatches == 0 && shadow.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
